// ===== src/line_sensor_classifier_macros.svh =====
// ---------------------------------------------------------------------------
// line_sensor_classifier_macros
// assertion macros shared by the line sensor classifier rtl
// ---------------------------------------------------------------------------
`ifndef LINE_SENSOR_CLASSIFIER_MACROS_SVH
`define LINE_SENSOR_CLASSIFIER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked outside reset
`define LSC_ASSERT_IMPL(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("lsc assertion failed");

// next-cycle implication, checked outside reset
`define LSC_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lsc assertion failed");

`else

`define LSC_ASSERT_IMPL(lbl, ck, rstn, ante, cons)
`define LSC_ASSERT_NEXT(lbl, ck, rstn, ante, cons)

`endif

`endif

// ===== src/lsc_pkg.sv =====
// ---------------------------------------------------------------------------
// lsc_pkg
// types and calibration constants of the line sensor classifier
// ---------------------------------------------------------------------------
package lsc_pkg;

  localparam int CHANNELS  = 8;
  localparam int SAMPLE_W  = 8;
  localparam int CAL_W     = 16;
  localparam int GAIN_W    = 12;
  localparam int IDX_W     = 3;
  localparam int COUNT_W   = 4;
  localparam int TOTAL_W   = 16;
  localparam int RUN_W     = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  // scans for darkest and brightest begin at this channel
  localparam logic [IDX_W-1:0] SCAN_START = 3'd3;
  localparam logic [RUN_W-1:0] RUN_MAX    = 3'd7;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_BLACK_THR    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FORK_CONFIRM = 1'b1;

  localparam logic signed [CAL_W-1:0] BLACK_THR_RST    = 16'sd492;
  localparam logic [RUN_W-1:0]        FORK_CONFIRM_RST = 3'd3;

  // per-channel gain, unsigned q0.16
  localparam logic [GAIN_W-1:0] CAL_GAIN [CHANNELS] = '{
    12'd2104, 12'd1652, 12'd3742, 12'd2962,
    12'd3854, 12'd2451, 12'd1239, 12'd4044
  };

  // per-channel offset, signed q4.12
  localparam logic signed [CAL_W-1:0] CAL_OFFS [CHANNELS] = '{
    -16'sd8974,  -16'sd6555, -16'sd12900, -16'sd10866,
    -16'sd13194, -16'sd8957, -16'sd5311,  -16'sd14051
  };

  typedef logic [IDX_W-1:0] ch_idx_t;

  typedef logic [CHANNELS-1:0][CAL_W-1:0] cal_vec_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
    logic [SAMPLE_W-1:0] sample_4;
    logic [SAMPLE_W-1:0] sample_5;
    logic [SAMPLE_W-1:0] sample_6;
    logic [SAMPLE_W-1:0] sample_7;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   darkest_index;
    logic [IDX_W-1:0]   brightest_index;
    logic [COUNT_W-1:0] black_count;
    logic               crossing;
    logic               fork_found;
    logic [TOTAL_W-1:0] crossing_total;
  } out_item_t;

  // classifier findings handed to the state update
  typedef struct packed {
    ch_idx_t            dark;
    ch_idx_t            bright;
    logic [COUNT_W-1:0] black_count;
    logic               all_black;
    logic               fork_pattern;
  } cls_res_t;

endpackage

// ===== src/lsc_calib.sv =====
// ---------------------------------------------------------------------------
// lsc_calib
// one channel: raw sample times gain, rounded to q4.12, plus offset, saturated
// ---------------------------------------------------------------------------
module lsc_calib
  import lsc_pkg::*;
#(
  parameter int                        USE_BITS = 8,
  parameter logic [GAIN_W-1:0]         GAIN     = 12'd0,
  parameter logic signed [CAL_W-1:0]   OFFS     = 16'sd0
) (
  input  logic [SAMPLE_W-1:0]       raw,
  output logic signed [CAL_W-1:0]   cal
);

  localparam int PROD_W = USE_BITS + GAIN_W;
  localparam int SHF_W  = PROD_W - 3;
  localparam int SUM_W  = ((SHF_W > CAL_W - 1) ? SHF_W : CAL_W - 1) + 2;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sd32767);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-32'sd32768);
  localparam logic [PROD_W:0]         RND_HALF = (PROD_W+1)'(8);

  logic [USE_BITS-1:0]     raw_u;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W:0]         rnd;
  logic [SHF_W-1:0]        shf;
  logic signed [SUM_W-1:0] sum;

  // scale and round half up to q4.12
  assign raw_u = raw[USE_BITS-1:0];
  assign prod  = PROD_W'(raw_u) * PROD_W'(GAIN);
  assign rnd   = {1'b0, prod} + RND_HALF;
  assign shf   = rnd[PROD_W:4];

  // add offset and clamp into q4.12 range
  assign sum = $signed(SUM_W'(shf)) + SUM_W'(OFFS);

  always_comb begin
    if (sum > SAT_HI) begin
      cal = CAL_W'(SAT_HI);
    end else if (sum < SAT_LO) begin
      cal = CAL_W'(SAT_LO);
    end else begin
      cal = CAL_W'(sum);
    end
  end

endmodule

// ===== src/lsc_classify.sv =====
// ---------------------------------------------------------------------------
// lsc_classify
// darkest and brightest channel, black count and fork pattern of one sample
// ---------------------------------------------------------------------------
module lsc_classify
  import lsc_pkg::*;
(
  input  cal_vec_t                  cal,
  input  logic signed [CAL_W-1:0]   black_thr,
  output cls_res_t                  res
);

  logic signed [CAL_W-1:0] v [CHANNELS];
  logic [CHANNELS-1:0]     is_black;
  ch_idx_t                 mn1 [4];
  ch_idx_t                 mx1 [4];
  ch_idx_t                 mn2 [2];
  ch_idx_t                 mx2 [2];
  ch_idx_t                 mn_w;
  ch_idx_t                 mx_w;
  logic [COUNT_W-1:0]      cnt;
  logic [1:0]              phase;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      v[i]        = $signed(cal[i]);
      is_black[i] = ($signed(cal[i]) < black_thr);
    end
  end

  // pairwise tree, lower index wins on ties
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mn1[i] = (v[2*i+1] < v[2*i]) ? IDX_W'(2*i+1) : IDX_W'(2*i);
      mx1[i] = (v[2*i+1] > v[2*i]) ? IDX_W'(2*i+1) : IDX_W'(2*i);
    end
    for (int j = 0; j < 2; j++) begin
      mn2[j] = (v[mn1[2*j+1]] < v[mn1[2*j]]) ? mn1[2*j+1] : mn1[2*j];
      mx2[j] = (v[mx1[2*j+1]] > v[mx1[2*j]]) ? mx1[2*j+1] : mx1[2*j];
    end
    mn_w = (v[mn2[1]] < v[mn2[0]]) ? mn2[1] : mn2[0];
    mx_w = (v[mx2[1]] > v[mx2[0]]) ? mx2[1] : mx2[0];
  end

  // the start channel keeps the title unless strictly beaten
  assign res.dark   = (v[mn_w] < v[SCAN_START]) ? mn_w : SCAN_START;
  assign res.bright = (v[mx_w] > v[SCAN_START]) ? mx_w : SCAN_START;

  // black count and black-white-black walk across the channels
  always_comb begin
    cnt   = '0;
    phase = 2'd0;
    for (int i = 0; i < CHANNELS; i++) begin
      cnt = cnt + COUNT_W'(is_black[i]);
      if (is_black[i]) begin
        if (phase == 2'd0 || phase == 2'd2) begin
          phase = phase + 2'd1;
        end
      end else if (phase == 2'd1) begin
        phase = 2'd2;
      end
    end
  end

  assign res.black_count  = cnt;
  assign res.all_black    = &is_black;
  assign res.fork_pattern = (phase == 2'd3);

endmodule

// ===== src/line_sensor_classifier.sv =====
// ---------------------------------------------------------------------------
// line_sensor_classifier
// calibrates eight line sensor channels and reports darkest and brightest
// channel, black count, crossing state and count, and confirmed fork
// ---------------------------------------------------------------------------
//
//   channel   ports                         carries
//   input     in_valid / in_ready / in_data  eight raw samples, one item
//   result    out_valid / out_ready / out_data  classification, one per item
//   config    cfg_valid / cfg_ready / cfg_index / cfg_data  register write
//
// an item is captured in the input register, then calibrated and classified
// in one pass into the result register. one item per cycle is sustained while
// the result is not stalled; the result register is the only stall point.
// a stalled result holds the input register once it is full, then in_ready drops.
// reset clears valids, crossing state, fork run and restores both registers.
// the config port never stalls.
//
`include "line_sensor_classifier_macros.svh"

module line_sensor_classifier
  import lsc_pkg::*;
#(
  parameter int SAMPLE_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_item_t                in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_item_t               out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_data
);

  localparam int USE_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

  // configuration registers
  logic signed [CAL_W-1:0] black_thr_r, black_thr_nxt;
  logic [RUN_W-1:0]        fork_cfm_r, fork_cfm_nxt;

  // pipeline registers
  logic       s1_valid_r, s1_valid_nxt;
  in_item_t   s1_data_r;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;

  // block state
  logic               xflag_r, xflag_nxt;
  logic [TOTAL_W-1:0] xcount_r, xcount_nxt;
  logic [RUN_W-1:0]   run_r, run_nxt;

  logic [SAMPLE_W-1:0] raw [CHANNELS];
  cal_vec_t            cal;
  cls_res_t            cls;
  logic                in_fire;
  logic                out_adv;
  logic                s1_move;
  logic                fork_hit;

  // handshake
  assign out_adv   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || out_adv;
  assign in_fire   = in_valid && in_ready;
  assign s1_move   = s1_valid_r && out_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_comb begin
    black_thr_nxt = black_thr_r;
    fork_cfm_nxt  = fork_cfm_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_BLACK_THR:    black_thr_nxt = $signed(cfg_data[CAL_W-1:0]);
        REG_FORK_CONFIRM: fork_cfm_nxt  = cfg_data[RUN_W-1:0];
        default:          ;
      endcase
    end
  end

  // per-channel calibration
  assign raw[0] = s1_data_r.sample_0;
  assign raw[1] = s1_data_r.sample_1;
  assign raw[2] = s1_data_r.sample_2;
  assign raw[3] = s1_data_r.sample_3;
  assign raw[4] = s1_data_r.sample_4;
  assign raw[5] = s1_data_r.sample_5;
  assign raw[6] = s1_data_r.sample_6;
  assign raw[7] = s1_data_r.sample_7;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_cal
    lsc_calib #(
      .USE_BITS (USE_BITS),
      .GAIN     (CAL_GAIN[g]),
      .OFFS     (CAL_OFFS[g])
    ) u_calib (
      .raw (raw[g]),
      .cal (cal[g])
    );
  end

  lsc_classify u_classify (
    .cal       (cal),
    .black_thr (black_thr_r),
    .res       (cls)
  );

  // crossing and fork state for the item leaving the input register
  always_comb begin
    xflag_nxt  = xflag_r;
    xcount_nxt = xcount_r;
    run_nxt    = run_r;
    fork_hit   = 1'b0;
    if (s1_move) begin
      xflag_nxt = cls.all_black;
      if (cls.all_black && !xflag_r) begin
        xcount_nxt = xcount_r + TOTAL_W'(1);
      end
      if (cls.fork_pattern) begin
        run_nxt  = (run_r < RUN_MAX) ? run_r + RUN_W'(1) : run_r;
        fork_hit = 1'b1;
      end else begin
        run_nxt = '0;
      end
    end
  end

  // result assembly
  always_comb begin
    out_data_nxt.darkest_index   = cls.dark;
    out_data_nxt.brightest_index = cls.bright;
    out_data_nxt.black_count     = cls.black_count;
    out_data_nxt.crossing        = xflag_nxt;
    out_data_nxt.fork_found      = fork_hit && (run_nxt >= fork_cfm_r);
    out_data_nxt.crossing_total  = xcount_nxt;
  end

  // valid tracking
  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_move ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      black_thr_r <= BLACK_THR_RST;
      fork_cfm_r  <= FORK_CONFIRM_RST;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      xflag_r     <= 1'b0;
      xcount_r    <= '0;
      run_r       <= '0;
    end else begin
      black_thr_r <= black_thr_nxt;
      fork_cfm_r  <= fork_cfm_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      xflag_r     <= xflag_nxt;
      xcount_r    <= xcount_nxt;
      run_r       <= run_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (s1_move) begin
      out_data_r <= out_data_nxt;
    end
  end

  // checks
  `LSC_ASSERT_IMPL(a_stall_only_when_full, clk, rst_n, !in_ready,
                   s1_valid_r && out_valid_r && !out_ready)
  `LSC_ASSERT_IMPL(a_crossing_all_black, clk, rst_n, out_valid_r && out_data_r.crossing,
                   out_data_r.black_count == COUNT_W'(CHANNELS))
  `LSC_ASSERT_IMPL(a_fork_mixed, clk, rst_n, out_valid_r && out_data_r.fork_found,
                   out_data_r.black_count >= 4'd2 && out_data_r.black_count <= 4'd7)
  `LSC_ASSERT_NEXT(a_count_sets_flag, clk, rst_n, s1_move && cls.all_black && !xflag_r,
                   xflag_r && xcount_r == $past(xcount_r) + TOTAL_W'(1))

endmodule

// ===== bench/line_sensor_classifier_tb.sv =====
// ---------------------------------------------------------------------------
// line_sensor_classifier_tb
// self-checking bench: drives raw eight-channel samples through the
// classifier, predicts calibration, darkest/brightest scan, black count,
// crossing state and count and the fork flag per item, and compares every
// result field. covers both registers at their extremes, ties, saturation,
// random idling on both sides and a long output stall.
// ---------------------------------------------------------------------------
module line_sensor_classifier_tb
  import lsc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [SAMPLE_W-1:0] raw_arr_t [CHANNELS];

  // calibration per channel: gain q0.16, offset q4.12
  localparam int CH_GAIN [CHANNELS] = '{2104, 1652, 3742, 2962, 3854, 2451, 1239, 4044};
  localparam int CH_OFFSET [CHANNELS] = '{-8974, -6555, -12900, -10866,
                                          -13194, -8957, -5311, -14051};
  localparam logic [7:0] SAT_CHANNELS = 8'h9C;  // channels 2, 3, 4, 7 can saturate high

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // predictor copy of registers and state
  logic signed [CAL_W-1:0] thr_lvl = 16'sd492;
  logic [RUN_W-1:0] fork_need = 3'd3;
  logic [RUN_W-1:0] fork_run = '0;
  logic xing_flag = 1'b0;
  logic [TOTAL_W-1:0] xing_total = '0;

  out_item_t verdict_q [$];
  out_item_t want;
  int in_idle_pct = 24;
  int out_idle_pct = 60;
  int hold_len = 0;
  int stall_cnt;
  int fail_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int crossings_seen = 0;

  line_sensor_classifier i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // calibrated level of one channel, rounded and saturated
  function automatic int cal_level(input int ch, input logic [SAMPLE_W-1:0] raw);
    longint v;
    v = ((longint'(raw) * CH_GAIN[ch] + 8) >>> 4) + CH_OFFSET[ch];
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return int'(v);
  endfunction

  // expected classification of one item, advances the predictor state
  function automatic out_item_t predict_verdict(input in_item_t it);
    raw_arr_t r;
    int cal [CHANNELS];
    int dark;
    int bright;
    int blacks;
    int phase;
    out_item_t v;
    r[0] = it.sample_0; r[1] = it.sample_1; r[2] = it.sample_2; r[3] = it.sample_3;
    r[4] = it.sample_4; r[5] = it.sample_5; r[6] = it.sample_6; r[7] = it.sample_7;
    for (int c = 0; c < CHANNELS; c++) cal[c] = cal_level(c, r[c]);
    dark = 3;
    bright = 3;
    blacks = 0;
    phase = 0;
    // scans start at channel 3, strict compare keeps earlier candidate on ties
    for (int c = 0; c < CHANNELS; c++) begin
      if (cal[c] < cal[dark]) dark = c;
      if (cal[c] > cal[bright]) bright = c;
      if (cal[c] < thr_lvl) begin
        blacks++;
        if (phase == 0 || phase == 2) phase++;
      end else if (phase == 1) begin
        phase++;
      end
    end
    // crossing entered on the first all-black item
    if (blacks == CHANNELS && !xing_flag) begin
      xing_total = xing_total + TOTAL_W'(1);
      xing_flag = 1'b1;
      crossings_seen++;
    end
    if (blacks < CHANNELS) xing_flag = 1'b0;
    v.fork_found = 1'b0;
    if (phase == 3) begin
      if (fork_run < RUN_MAX) fork_run = fork_run + RUN_W'(1);
      v.fork_found = (fork_run >= fork_need);
    end else begin
      fork_run = '0;
    end
    v.darkest_index = dark[IDX_W-1:0];
    v.brightest_index = bright[IDX_W-1:0];
    v.black_count = blacks[COUNT_W-1:0];
    v.crossing = xing_flag;
    v.crossing_total = xing_total;
    return v;
  endfunction

  function automatic in_item_t pack_item(input raw_arr_t r);
    in_item_t it;
    it.sample_0 = r[0]; it.sample_1 = r[1]; it.sample_2 = r[2]; it.sample_3 = r[3];
    it.sample_4 = r[4]; it.sample_5 = r[5]; it.sample_6 = r[6]; it.sample_7 = r[7];
    return it;
  endfunction

  function automatic in_item_t fill_item(input logic [7:0] even, input logic [7:0] odd);
    raw_arr_t r;
    for (int c = 0; c < CHANNELS; c++) r[c] = c[0] ? odd : even;
    return pack_item(r);
  endfunction

  // raw value landing on the wanted side of the threshold, random if none found
  function automatic logic [7:0] pick_raw(input int ch, input logic want_black);
    logic [7:0] r;
    for (int t = 0; t < 32; t++) begin
      r = 8'($urandom_range(255));
      if ((cal_level(ch, r) < thr_lvl) == want_black) return r;
    end
    return r;
  endfunction

  // two raw values giving equal calibrated levels on channels a and b
  function automatic logic find_tie(input int a, input int b,
                                    output logic [7:0] ra, output logic [7:0] rb);
    for (int x = 0; x < 256; x++) begin
      for (int y = 0; y < 256; y++) begin
        if (cal_level(a, 8'(x)) == cal_level(b, 8'(y))) begin
          ra = 8'(x);
          rb = 8'(y);
          return 1'b1;
        end
      end
    end
    ra = '0;
    rb = '0;
    return 1'b0;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  // send one item, with random idle cycles ahead of it
  task automatic send_sample(input in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    verdict_q.push_back(predict_verdict(it));
    items_sent++;
    @(negedge clk);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BLACK_THR) thr_lvl = data;
    else if (idx == REG_FORK_CONFIRM) fork_need = data[RUN_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random episodes of items sharing one black/white shape, or of random and saturating raw values
  task automatic run_episodes(input int n_items);
    int done;
    int kind;
    int len;
    int p;
    int q;
    int s;
    logic [7:0] mask;
    logic [7:0] sat;
    raw_arr_t r;
    done = 0;
    while (done < n_items) begin
      kind = $urandom_range(99);
      len = $urandom_range(1, 10);
      mask = 8'($urandom);
      sat = 8'($urandom_range(255)) & SAT_CHANNELS;
      if (kind < 35) begin
        // black, white, black somewhere across the channels
        p = $urandom_range(0, 5);
        q = $urandom_range(p + 1, 6);
        s = $urandom_range(q + 1, 7);
        mask[p] = 1'b1;
        mask[q] = 1'b0;
        mask[s] = 1'b1;
      end else if (kind < 50) begin
        mask = 8'hFF;
      end else if (kind < 60) begin
        mask = 8'h00;
      end
      repeat (len) begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (kind >= 90) r[c] = sat[c] ? 8'($urandom_range(236, 255)) : 8'($urandom_range(255));
          else if (kind >= 75) r[c] = 8'($urandom_range(255));
          else r[c] = pick_raw(c, mask[c]);
        end
        send_sample(pack_item(r));
      end
      done += len;
    end
  endtask

  task automatic test_extremes();
    send_sample(fill_item(8'h00, 8'h00));
    send_sample(fill_item(8'hFF, 8'hFF));
    send_sample(fill_item(8'h55, 8'hAA));
    send_sample(fill_item(8'hAA, 8'h55));
  endtask

  task automatic test_ties();
    raw_arr_t r;
    // saturated channels tie at the top, channel 3 not among them
    for (int c = 0; c < CHANNELS; c++) r[c] = 8'hFF;
    r[3] = 8'h00;
    send_sample(pack_item(r));
    // equal levels at the bottom, once with channel 3 and once without
    for (int c = 0; c < CHANNELS; c++) r[c] = 8'hFF;
    void'(find_tie(3, 0, r[3], r[0]));
    send_sample(pack_item(r));
    for (int c = 0; c < CHANNELS; c++) r[c] = 8'hFF;
    void'(find_tie(1, 5, r[1], r[5]));
    send_sample(pack_item(r));
  endtask

  task automatic test_crossing();
    send_sample(fill_item(8'h00, 8'h00));
    send_sample(fill_item(8'h00, 8'h00));
    send_sample(fill_item(8'h00, 8'hFF));
    send_sample(fill_item(8'h00, 8'h00));
  endtask

  task automatic test_fork();
    // run saturates, flag from the confirm count onward
    repeat (8) send_sample(fill_item(8'd10, 8'd200));
    send_sample(fill_item(8'd200, 8'd200));
    write_reg(REG_FORK_CONFIRM, 16'h0000);
    send_sample(fill_item(8'd10, 8'd200));
    write_reg(REG_FORK_CONFIRM, 16'hFFFF);
    send_sample(fill_item(8'd10, 8'd200));
    write_reg(REG_FORK_CONFIRM, 16'h0003);
  endtask

  task automatic test_thresholds();
    write_reg(REG_BLACK_THR, 16'h8000);
    send_sample(fill_item(8'h00, 8'h00));
    write_reg(REG_BLACK_THR, 16'h7FFF);
    send_sample(fill_item(8'hFF, 8'hFF));
    write_reg(REG_BLACK_THR, 16'd492);
  endtask

  task automatic test_random_traffic(input int in_pct, input int out_pct, input int n_items);
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    repeat (2) begin
      write_reg(REG_BLACK_THR, 16'($urandom_range(0, 20000) - 4000));
      write_reg(REG_FORK_CONFIRM, 16'($urandom));
      run_episodes(n_items / 2);
    end
  endtask

  // long output stall fills the block, then a pause until all results are back
  task automatic test_backpressure();
    hold_len = 150;
    run_episodes(12);
    drain_results();
    run_episodes(4);
  endtask

  // receiver: random stalls, or a counted hold-off when requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_len != 0) begin
        out_ready <= 1'b0;
        for (stall_cnt = 0; stall_cnt < hold_len; stall_cnt++) @(negedge clk);
        hold_len = 0;
      end
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // result check against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        $error("result arrived with no item outstanding");
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        check_field("darkest_index", 16'(want.darkest_index), 16'(out_data.darkest_index));
        check_field("brightest_index", 16'(want.brightest_index),
                    16'(out_data.brightest_index));
        check_field("black_count", 16'(want.black_count), 16'(out_data.black_count));
        check_field("crossing", 16'(want.crossing), 16'(out_data.crossing));
        check_field("fork_found", 16'(want.fork_found), 16'(out_data.fork_found));
        check_field("crossing_total", want.crossing_total, out_data.crossing_total);
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_extremes();
    test_ties();
    test_crossing();
    test_fork();
    test_thresholds();
    test_random_traffic(24, 60, 570);
    test_random_traffic(60, 24, 570);
    test_backpressure();
    test_random_traffic(0, 0, 570);
    drain_results();
    repeat (10) @(negedge clk);
    $display("run covered %0d items and %0d results, %0d crossings entered",
             items_sent, results_seen, crossings_seen);
    $display("threshold and confirm extremes, ties, saturation, long output stall");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
